>>> sv/flsa_pkg.sv
package flsa_pkg;

   // Pool geometry
   localparam int POOL_SLOTS = 256;
   localparam int SLOT_W     = 8;
   localparam int COUNT_W    = 9;
   localparam int LINK_W     = SLOT_W + 1;

   localparam logic [COUNT_W-1:0] POOL_COUNT = COUNT_W'(POOL_SLOTS);

   // Command codes
   localparam logic CMD_ALLOC = 1'b0;
   localparam logic CMD_FREE  = 1'b1;

   // Configuration port
   localparam int CSR_DATA_W = 32;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_IDX_W  = 1;

   localparam logic [CSR_IDX_W-1:0] REG_MAX_IN_USE = 1'b0;

   localparam logic [COUNT_W-1:0] MAX_IN_USE_RESET = COUNT_W'(256);

   typedef struct packed {
      logic              cmd;
      logic [SLOT_W-1:0] slot_index;
   } req_type;

   typedef struct packed {
      logic [SLOT_W-1:0]  granted_index;
      logic               ok;
      logic [COUNT_W-1:0] count_after;
   } rsp_type;

   // One entry of the free list: the slot behind this one, and whether this one is last.
   typedef struct packed {
      logic              last;
      logic [SLOT_W-1:0] next;
   } link_type;

endpackage

>>> sv/flsa_ram.sv
module flsa_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> sv/free_list_slot_allocator_top.sv
// An accepted request has its result registered onto rsp in the following cycle.
// Throughput: one request per cycle unless rsp stalls; the link RAM is read at the
// address of the next free-list head, so back-to-back allocates and frees need no wait.
// Reset is synchronous: the free list is empty, the in-use count is zero and
// max_in_use returns to 256. The link RAM is not cleared and needs no clearing pass.
module free_list_slot_allocator_top (
   input  logic                                 clock,
   input  logic                                 reset,

   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  flsa_pkg::req_type                    req_payload,

   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output flsa_pkg::rsp_type                    rsp_payload,

   input  logic                                 csr_psel,
   input  logic                                 csr_penable,
   input  logic                                 csr_pwrite,
   input  logic [flsa_pkg::CSR_ADDR_W-1:0]      csr_paddr,
   input  logic [flsa_pkg::CSR_DATA_W-1:0]      csr_pwdata,
   output logic [flsa_pkg::CSR_DATA_W-1:0]      csr_prdata,
   output logic                                 csr_pready
);

   logic [flsa_pkg::SLOT_W-1:0]  free_head_ff, free_head_in;
   logic                         list_empty_ff, list_empty_in;
   logic [flsa_pkg::COUNT_W-1:0] count_ff, count_in;
   logic [flsa_pkg::COUNT_W-1:0] max_in_use_ff;
   logic                         rsp_valid_ff, rsp_valid_in;
   flsa_pkg::rsp_type            rsp_ff, rsp_in;
   logic                         fwd_sel_ff, fwd_sel_in;
   flsa_pkg::link_type           fwd_link_ff, fwd_link_in;

   logic                         accept;
   logic                         wr_en;
   flsa_pkg::link_type           wr_link;
   logic [flsa_pkg::LINK_W-1:0]  ram_rd_data;
   flsa_pkg::link_type           head_link;
   logic [flsa_pkg::COUNT_W-1:0] limit;
   logic [flsa_pkg::SLOT_W-1:0]  granted;
   logic                         ok;
   logic [flsa_pkg::CSR_IDX_W-1:0] csr_index;
   logic                         csr_write;

   assign req_stall = rsp_valid_ff & rsp_stall;
   assign accept    = req_valid & ~req_stall;

   // Configuration port
   assign csr_pready = 1'b1;
   assign csr_index  = csr_paddr[flsa_pkg::CSR_ADDR_W-1:2];
   assign csr_write  = csr_psel & csr_penable & csr_pwrite & csr_pready;

   always_comb begin
      csr_prdata = '0;
      if (csr_index == flsa_pkg::REG_MAX_IN_USE) begin
         csr_prdata = flsa_pkg::CSR_DATA_W'(max_in_use_ff);
      end
   end

   // The RAM output is the link of the current head, except just after a free, whose
   // link was written in the same cycle as it was read and so comes from the bypass.
   assign head_link = fwd_sel_ff ? fwd_link_ff : flsa_pkg::link_type'(ram_rd_data);

   assign limit = (max_in_use_ff < flsa_pkg::POOL_COUNT) ? max_in_use_ff
                                                         : flsa_pkg::POOL_COUNT;

   always_comb begin
      free_head_in  = free_head_ff;
      list_empty_in = list_empty_ff;
      count_in      = count_ff;
      wr_en         = 1'b0;
      wr_link.last  = list_empty_ff;
      wr_link.next  = free_head_ff;
      granted       = '0;
      ok            = 1'b0;

      if (accept) begin
         if (req_payload.cmd == flsa_pkg::CMD_ALLOC) begin
            if (!list_empty_ff) begin
               granted       = free_head_ff;
               free_head_in  = head_link.next;
               list_empty_in = head_link.last;
               if (count_ff < flsa_pkg::POOL_COUNT) begin
                  count_in = count_ff + flsa_pkg::COUNT_W'(1);
               end
               ok = 1'b1;
            end else if (count_ff < limit) begin
               granted  = count_ff[flsa_pkg::SLOT_W-1:0];
               count_in = count_ff + flsa_pkg::COUNT_W'(1);
               ok       = 1'b1;
            end
         end else if (flsa_pkg::COUNT_W'(req_payload.slot_index) < flsa_pkg::POOL_COUNT) begin
            wr_en         = 1'b1;
            free_head_in  = req_payload.slot_index;
            list_empty_in = 1'b0;
            if (count_ff != '0) begin
               count_in = count_ff - flsa_pkg::COUNT_W'(1);
            end
            ok = 1'b1;
         end
      end

      fwd_sel_in  = wr_en;
      fwd_link_in = wr_link;

      rsp_in.granted_index = granted;
      rsp_in.ok            = ok;
      rsp_in.count_after   = count_in;

      if (accept) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   flsa_ram #(
      .WIDTH (flsa_pkg::LINK_W),
      .DEPTH (flsa_pkg::POOL_SLOTS)
   ) u_link_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (req_payload.slot_index),
      .wr_data (wr_link),
      .rd_addr (free_head_in),
      .rd_data (ram_rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         free_head_ff  <= '0;
         list_empty_ff <= 1'b1;
         count_ff      <= '0;
         max_in_use_ff <= flsa_pkg::MAX_IN_USE_RESET;
         rsp_valid_ff  <= 1'b0;
         fwd_sel_ff    <= 1'b0;
      end else begin
         free_head_ff  <= free_head_in;
         list_empty_ff <= list_empty_in;
         count_ff      <= count_in;
         rsp_valid_ff  <= rsp_valid_in;
         fwd_sel_ff    <= fwd_sel_in;
         if (csr_write && csr_index == flsa_pkg::REG_MAX_IN_USE) begin
            max_in_use_ff <= csr_pwdata[flsa_pkg::COUNT_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      fwd_link_ff <= fwd_link_in;
      if (accept) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule

>>> sv/flsa_checker.sv
module flsa_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_stall,
   input flsa_pkg::req_type req_payload,
   input logic              rsp_valid,
   input logic              rsp_stall,
   input flsa_pkg::rsp_type rsp_payload
);

   // A result that is held back stays offered.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("result withdrawn while stalled");

   // Every accepted request has its result offered in the following cycle.
   assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> rsp_valid)
      else $error("accepted request produced no result");

   // A free of a slot inside the pool always takes effect.
   assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && req_payload.cmd == flsa_pkg::CMD_FREE
      |=> rsp_payload.ok)
      else $error("free was refused");

   // A refused request grants nothing.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_payload.ok |-> rsp_payload.granted_index == '0)
      else $error("failed request carries a slot");

   // The in-use count never passes the pool size.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_payload.count_after <= flsa_pkg::POOL_COUNT)
      else $error("in-use count beyond pool size");

endmodule

bind free_list_slot_allocator_top flsa_checker u_flsa_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_valid),
   .req_stall   (req_stall),
   .req_payload (req_payload),
   .rsp_valid   (rsp_valid),
   .rsp_stall   (rsp_stall),
   .rsp_payload (rsp_payload)
);
